@@ hw/rtl/adcrr_pkg.sv @@
package adcrr_pkg;

  localparam int CHANNEL_COUNT = 8;

  localparam int CHAN_W   = 3;
  localparam int RES_W    = 2;
  localparam int OVS_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int VDDA_W   = 16;

  localparam int VREF_W   = 12;
  localparam int RESC_W   = 14;
  localparam int OVSC_W   = 28;
  localparam int CFG_W    = 28;
  localparam int CFG_IDX_W = 2;

  // 3000 * 4095 fits in 24 bits
  localparam int DIVIDEND_W = 24;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_VREFINT_CAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLING   = 2'd2;

  localparam logic [VREF_W-1:0] VREFINT_CAL_RESET = 12'd1655;
  localparam logic [VREF_W-1:0] VREF_MV           = 12'd3000;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_EOC     = 1'b1;

  localparam logic OUT_KIND_START = 1'b0;
  localparam logic OUT_KIND_DONE  = 1'b1;

  localparam logic [CHAN_W-1:0] REF_CHANNEL      = 3'd7;
  localparam logic [RES_W-1:0]  REF_RESOLUTION   = 2'd0;
  localparam logic [OVS_W-1:0]  REF_OVERSAMPLING = 4'd8;
  localparam logic [OVS_W-1:0]  OVS_MAX          = 4'd8;

  localparam logic [RES_W-1:0] RES_12BIT = 2'd0;
  localparam logic [RES_W-1:0] RES_10BIT = 2'd1;
  localparam logic [RES_W-1:0] RES_8BIT  = 2'd2;
  localparam logic [RES_W-1:0] RES_6BIT  = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PEND,
    ACT_BEGIN,
    ACT_DIVIDE,
    ACT_DONE
  } action_t;

  typedef enum logic [1:0] {
    OUT_BEGIN,
    OUT_CHAN,
    OUT_DONE
  } out_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_EMIT_BEGIN,
    ST_EMIT_CHAN,
    ST_EMIT_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     set_pending;
    logic     set_active_req;
    logic     div_start;
    logic     store_vdda;
    logic     load;
    out_sel_t sel;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    div_done;
    logic    out_free;
    logic    found;
  } status_t;

endpackage

@@ hw/rtl/adcrr_div.sv @@
module adcrr_div import adcrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [VDDA_W-1:0]     divisor,
  output logic                  done,
  output logic [VDDA_W-1:0]     quotient
);

  localparam logic [DIV_CNT_W-1:0] STEPS = DIV_CNT_W'(DIVIDEND_W);

  logic                  running;
  logic [DIV_CNT_W-1:0]  count;
  logic [VDDA_W-1:0]     rem;
  logic [DIVIDEND_W-1:0] quo;

  logic [VDDA_W:0]       trial;
  logic                  fits;

  // One quotient bit a step. A zero divisor gives all ones, which saturates.
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= STEPS;
      end else if (running) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= fits ? VDDA_W'(trial - {1'b0, divisor}) : trial[VDDA_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = (|quo[DIVIDEND_W-1:VDDA_W]) ? {VDDA_W{1'b1}} : quo[VDDA_W-1:0];

endmodule

@@ hw/rtl/adcrr_dp.sv @@
module adcrr_dp import adcrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 kind,
  input  logic [CHAN_W-1:0]    req_channel,
  input  logic [SAMPLE_W-1:0]  raw_sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 out_kind,
  output logic [CHAN_W-1:0]    conv_channel,
  output logic [RES_W-1:0]     conv_resolution,
  output logic [OVS_W-1:0]     conv_oversampling,
  output logic [SAMPLE_W-1:0]  sample_value,
  output logic [VDDA_W-1:0]    vdda_mv,
  output logic                 last
);

  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] ch;
  } search_t;

  logic [VREF_W-1:0]        vrefint_cal;
  logic [RESC_W-1:0]        resolution_codes;
  logic [OVSC_W-1:0]        oversampling_codes;

  logic                     kind_q;
  logic [CHAN_W-1:0]        req_q;
  logic [SAMPLE_W-1:0]      raw_q;

  logic                     busy;
  logic                     phase_measure;
  logic [CHAN_W-1:0]        active_channel;
  logic [CHANNEL_COUNT-1:0] pending_flags;
  logic [VDDA_W-1:0]        vdda_latest;

  logic [RES_W-1:0]         res_tab [0:7];
  logic [OVS_W-1:0]         ovs_tab [0:7];
  logic [RES_W-1:0]         active_res;
  logic [OVS_W-1:0]         active_ovs;
  logic [SAMPLE_W-1:0]      aligned;
  logic [CHANNEL_COUNT-1:0] req_mask;
  logic [CHANNEL_COUNT-1:0] active_mask;
  logic                     req_in_range;
  search_t                  next_pick;

  logic [DIVIDEND_W-1:0]    dividend;
  logic                     div_done;
  logic [VDDA_W-1:0]        quotient;

  function automatic search_t rr_search(input logic [CHANNEL_COUNT-1:0] flags,
                                        input logic [CHAN_W-1:0] from);
    search_t r;
    int      t;
    r = '0;
    for (int i = CHANNEL_COUNT - 1; i >= 1; i--) begin
      t = int'(from) + i;
      if (t >= CHANNEL_COUNT) t = t - CHANNEL_COUNT;
      if (flags[t[CHAN_W-1:0]]) begin
        r.found = 1'b1;
        r.ch    = CHAN_W'(t);
      end
    end
    return r;
  endfunction

  // Per-channel codes; the reference channel is fixed
  always_comb begin
    for (int c = 0; c < 7; c++) begin
      res_tab[c] = resolution_codes[2*c +: RES_W];
      ovs_tab[c] = (oversampling_codes[4*c +: OVS_W] > OVS_MAX) ?
                   OVS_MAX : oversampling_codes[4*c +: OVS_W];
    end
    res_tab[7] = REF_RESOLUTION;
    ovs_tab[7] = REF_OVERSAMPLING;
  end

  assign active_res = res_tab[active_channel];
  assign active_ovs = ovs_tab[active_channel];

  always_comb begin
    unique case (active_res)
      RES_12BIT: aligned = {raw_q[11:0], 4'b0};
      RES_10BIT: aligned = {raw_q[9:0], 6'b0};
      RES_8BIT:  aligned = {raw_q[7:0], 8'b0};
      RES_6BIT:  aligned = {raw_q[5:0], 10'b0};
    endcase
  end

  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      req_mask[i]    = int'(req_q) == i;
      active_mask[i] = int'(active_channel) == i;
    end
  end

  assign req_in_range = int'(req_q) < CHANNEL_COUNT;
  assign next_pick    = rr_search(pending_flags, active_channel);

  always_comb begin
    status.div_done = div_done;
    status.out_free = !result_valid || !result_stall;
    status.found    = next_pick.found;
    if (kind_q == KIND_REQUEST) begin
      if (!req_in_range)  status.action = ACT_NONE;
      else if (busy)      status.action = ACT_PEND;
      else                status.action = ACT_BEGIN;
    end else begin
      if (!busy)               status.action = ACT_NONE;
      else if (!phase_measure) status.action = ACT_DIVIDE;
      else                     status.action = ACT_DONE;
    end
  end

  assign dividend = DIVIDEND_W'(vrefint_cal) * DIVIDEND_W'(VREF_MV);

  adcrr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (raw_q),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vrefint_cal        <= VREFINT_CAL_RESET;
      resolution_codes   <= '0;
      oversampling_codes <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VREFINT_CAL:  vrefint_cal        <= cfg_data[VREF_W-1:0];
        CFG_RESOLUTION:   resolution_codes   <= cfg_data[RESC_W-1:0];
        CFG_OVERSAMPLING: oversampling_codes <= cfg_data[OVSC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      req_q  <= req_channel;
      raw_q  <= raw_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      phase_measure  <= 1'b0;
      active_channel <= '0;
      pending_flags  <= '0;
      vdda_latest    <= '0;
    end else begin
      if (cmd.set_pending)    pending_flags  <= pending_flags | req_mask;
      if (cmd.set_active_req) active_channel <= req_q;
      if (cmd.store_vdda)     vdda_latest    <= quotient;
      if (cmd.load) begin
        unique case (cmd.sel)
          OUT_BEGIN: begin
            busy          <= 1'b1;
            phase_measure <= 1'b0;
            pending_flags <= pending_flags & ~active_mask;
          end
          OUT_CHAN: phase_measure <= 1'b1;
          OUT_DONE: begin
            busy          <= 1'b0;
            phase_measure <= 1'b0;
            // hand the next sequence its channel
            if (next_pick.found) active_channel <= next_pick.ch;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vdda_mv <= vdda_latest;
      unique case (cmd.sel)
        OUT_BEGIN: begin
          out_kind          <= OUT_KIND_START;
          conv_channel      <= REF_CHANNEL;
          conv_resolution   <= REF_RESOLUTION;
          conv_oversampling <= REF_OVERSAMPLING;
          sample_value      <= '0;
          last              <= 1'b1;
        end
        OUT_CHAN: begin
          out_kind          <= OUT_KIND_START;
          conv_channel      <= active_channel;
          conv_resolution   <= active_res;
          conv_oversampling <= active_ovs;
          sample_value      <= '0;
          last              <= 1'b1;
        end
        OUT_DONE: begin
          out_kind          <= OUT_KIND_DONE;
          conv_channel      <= active_channel;
          conv_resolution   <= '0;
          conv_oversampling <= '0;
          sample_value      <= aligned;
          last              <= !next_pick.found;
        end
        default: begin
          out_kind          <= OUT_KIND_START;
          conv_channel      <= '0;
          conv_resolution   <= '0;
          conv_oversampling <= '0;
          sample_value      <= '0;
          last              <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/adcrr_ctrl.sv @@
module adcrr_ctrl import adcrr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = OUT_BEGIN;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        unique case (status.action)
          ACT_PEND: begin
            cmd.set_pending = 1'b1;
            state_next      = ST_IDLE;
          end
          ACT_BEGIN: begin
            cmd.set_active_req = 1'b1;
            state_next         = ST_EMIT_BEGIN;
          end
          ACT_DIVIDE: begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
          ACT_DONE: state_next = ST_EMIT_DONE;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.store_vdda = 1'b1;
          state_next     = ST_EMIT_CHAN;
        end
      end
      ST_EMIT_BEGIN: begin
        cmd.sel = OUT_BEGIN;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_CHAN: begin
        cmd.sel = OUT_CHAN;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_DONE: begin
        cmd.sel = OUT_DONE;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          // chain straight into the next pending channel
          state_next = status.found ? ST_EMIT_BEGIN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/adc_round_robin_conversion_sequencer.sv @@
// A request is captured, decided in ST_DECIDE, and its start command loaded into the
// output register from ST_EMIT_BEGIN; for an end of reference conversion the 24-step
// restoring divider forms the supply estimate, then ST_EMIT_CHAN loads its command.
// Throughput: one beat in at a time; the next is taken once the previous one's last
// result sits in the output register, or once a beat with no result is decided.
// Reset (rst, synchronous): idle, nothing pending, supply estimate 0.
module adc_round_robin_conversion_sequencer import adcrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 kind,
  input  logic [CHAN_W-1:0]    req_channel,
  input  logic [SAMPLE_W-1:0]  raw_sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 out_kind,
  output logic [CHAN_W-1:0]    conv_channel,
  output logic [RES_W-1:0]     conv_resolution,
  output logic [OVS_W-1:0]     conv_oversampling,
  output logic [SAMPLE_W-1:0]  sample_value,
  output logic [VDDA_W-1:0]    vdda_mv,
  output logic                 last
);

  cmd_t    cmd;
  status_t status;

  adcrr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  adcrr_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .kind              (kind),
    .req_channel       (req_channel),
    .raw_sample        (raw_sample),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .out_kind          (out_kind),
    .conv_channel      (conv_channel),
    .conv_resolution   (conv_resolution),
    .conv_oversampling (conv_oversampling),
    .sample_value      (sample_value),
    .vdda_mv           (vdda_mv),
    .last              (last)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import adcrr_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BEATS   = 360;
  localparam int HOLD_CYCLES   = 400;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic                okind;
    logic [CHAN_W-1:0]   chan;
    logic [RES_W-1:0]    res;
    logic [OVS_W-1:0]    ovs;
    logic [SAMPLE_W-1:0] sample;
    logic [VDDA_W-1:0]   vdda;
    logic                lst;
  } conv_result_t;

  // Tracks the sequencer state and queues the start/done beats each event causes.
  class conv_predictor;
    logic [VREF_W-1:0]        vref_cal;
    logic [RESC_W-1:0]        res_codes;
    logic [OVSC_W-1:0]        ovs_codes;
    bit                       busy;
    bit                       measuring;
    logic [CHAN_W-1:0]        active;
    logic [CHANNEL_COUNT-1:0] pending;
    logic [VDDA_W-1:0]        vdda;
    conv_result_t             awaited_q[$];
    int                       n_start;
    int                       n_done;
    int                       n_queued;
    int                       n_ignored;

    function new();
      vref_cal  = VREFINT_CAL_RESET;
      res_codes = '0;
      ovs_codes = '0;
      busy      = 0;
      measuring = 0;
      active    = '0;
      pending   = '0;
      vdda      = '0;
      n_start   = 0;
      n_done    = 0;
      n_queued  = 0;
      n_ignored = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      unique case (idx)
        CFG_VREFINT_CAL:  vref_cal  = data[VREF_W-1:0];
        CFG_RESOLUTION:   res_codes = data[RESC_W-1:0];
        CFG_OVERSAMPLING: ovs_codes = data[OVSC_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RES_W-1:0] res_of(logic [CHAN_W-1:0] ch);
      if (ch == REF_CHANNEL) return REF_RESOLUTION;
      return res_codes[2*ch +: RES_W];
    endfunction

    function logic [OVS_W-1:0] ovs_of(logic [CHAN_W-1:0] ch);
      logic [OVS_W-1:0] c;
      if (ch == REF_CHANNEL) return REF_OVERSAMPLING;
      c = ovs_codes[4*ch +: OVS_W];
      return (c > OVS_MAX) ? OVS_MAX : c;
    endfunction

    function void push(logic ok, logic [CHAN_W-1:0] ch, logic [RES_W-1:0] rs,
                       logic [OVS_W-1:0] ov, logic [SAMPLE_W-1:0] smp);
      conv_result_t r;
      r.okind  = ok;
      r.chan   = ch;
      r.res    = rs;
      r.ovs    = ov;
      r.sample = smp;
      r.vdda   = vdda;
      r.lst    = 1'b0;
      awaited_q.push_back(r);
    endfunction

    // Open a sequence: reference conversion first.
    function void start_seq(logic [CHAN_W-1:0] ch);
      busy        = 1;
      measuring   = 0;
      active      = ch;
      pending[ch] = 1'b0;
      push(OUT_KIND_START, REF_CHANNEL, REF_RESOLUTION, REF_OVERSAMPLING, '0);
      n_start++;
    endfunction

    function void take_event(logic k, logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] raw);
      int unsigned         quot;
      logic [SAMPLE_W-1:0] aligned;
      logic [CHAN_W-1:0]   fin;
      logic [CHAN_W-1:0]   c;
      bit                  found;
      conv_result_t        tail;
      if (k == KIND_REQUEST) begin
        if (ch >= CHANNEL_COUNT) begin
          n_ignored++;
          return;
        end
        if (busy) begin
          pending[ch] = 1'b1;
          n_queued++;
          return;
        end
        start_seq(ch);
      end else begin
        if (!busy) begin
          n_ignored++;
          return;
        end
        if (!measuring) begin
          if (raw == 0) begin
            quot = 32'hFFFF;
          end else begin
            quot = (int'(VREF_MV) * int'(vref_cal)) / int'(raw);
            if (quot > 32'hFFFF) quot = 32'hFFFF;
          end
          vdda      = quot[VDDA_W-1:0];
          measuring = 1;
          push(OUT_KIND_START, active, res_of(active), ovs_of(active), '0);
          n_start++;
        end else begin
          aligned = raw << (4 + 2 * res_of(active));
          push(OUT_KIND_DONE, active, '0, '0, aligned);
          n_done++;
          busy      = 0;
          measuring = 0;
          fin       = active;
          found     = 0;
          // Search after the finished channel; skip the finished one itself.
          for (int i = 1; i < CHANNEL_COUNT; i++) begin
            c = CHAN_W'((fin + i) % CHANNEL_COUNT);
            if (!found && pending[c]) begin
              start_seq(c);
              found = 1;
            end
          end
        end
      end
      tail = awaited_q.pop_back();
      tail.lst = 1'b1;
      awaited_q.push_back(tail);
    endfunction

    function bit match_result(conv_result_t got, output string msg);
      conv_result_t want;
      if (awaited_q.size() == 0) begin
        msg = $sformatf(" result with none awaited: kind %0d ch %0d", got.okind, got.chan);
        return 0;
      end
      want = awaited_q.pop_front();
      msg = "";
      if (got.okind !== want.okind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.okind, want.okind)};
      if (got.chan !== want.chan)
        msg = {msg, $sformatf(" channel %0d/%0d", got.chan, want.chan)};
      if (got.res !== want.res)
        msg = {msg, $sformatf(" resolution %0d/%0d", got.res, want.res)};
      if (got.ovs !== want.ovs)
        msg = {msg, $sformatf(" oversampling %0d/%0d", got.ovs, want.ovs)};
      if (got.sample !== want.sample)
        msg = {msg, $sformatf(" sample %h/%h", got.sample, want.sample)};
      if (got.vdda !== want.vdda)
        msg = {msg, $sformatf(" vdda %0d/%0d", got.vdda, want.vdda)};
      if (got.lst !== want.lst)
        msg = {msg, $sformatf(" last %0d/%0d", got.lst, want.lst)};
      return msg == "";
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 kind;
  logic [CHAN_W-1:0]    req_channel;
  logic [SAMPLE_W-1:0]  raw_sample;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 out_kind;
  logic [CHAN_W-1:0]    conv_channel;
  logic [RES_W-1:0]     conv_resolution;
  logic [OVS_W-1:0]     conv_oversampling;
  logic [SAMPLE_W-1:0]  sample_value;
  logic [VDDA_W-1:0]    vdda_mv;
  logic                 last;

  conv_predictor model = new();
  int errors        = 0;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_left     = 0;

  adc_round_robin_conversion_sequencer u_top (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .kind              (kind),
    .req_channel       (req_channel),
    .raw_sample        (raw_sample),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .out_kind          (out_kind),
    .conv_channel      (conv_channel),
    .conv_resolution   (conv_resolution),
    .conv_oversampling (conv_oversampling),
    .sample_value      (sample_value),
    .vdda_mv           (vdda_mv),
    .last              (last)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    if (errors < PRINT_CAP) $display("mismatch at %0t:%s", $time, msg);
    errors++;
  endtask

  // Check outputs before noting the input beat of the same edge.
  always @(posedge clk) begin : monitor
    conv_result_t got;
    string        msg;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got.okind  = out_kind;
        got.chan   = conv_channel;
        got.res    = conv_resolution;
        got.ovs    = conv_oversampling;
        got.sample = sample_value;
        got.vdda   = vdda_mv;
        got.lst    = last;
        if (!model.match_result(got, msg)) report(msg);
      end
      if (item_valid && !item_stall) model.take_event(kind, req_channel, raw_sample);
    end
  end

  // Hold the output off for a counted stretch, otherwise stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall = ($urandom_range(99) < sink_stall_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] ref_reading();
    unique case ($urandom_range(9))
      0:       return '0;
      1:       return SAMPLE_W'($urandom_range(300, 1));
      2:       return '1;
      3, 4, 5: return SAMPLE_W'($urandom_range(2200, 1200));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Enter and leave on a falling edge.
  task automatic send_item(input logic k, input logic [CHAN_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid  = 1'b1;
    kind        = k;
    req_channel = ch;
    raw_sample  = raw;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic configure(input logic [VREF_W-1:0] vref, input logic [RESC_W-1:0] res,
                           input logic [OVSC_W-1:0] ovs);
    write_cfg(CFG_VREFINT_CAL, CFG_W'(vref));
    write_cfg(CFG_RESOLUTION, CFG_W'(res));
    write_cfg(CFG_OVERSAMPLING, CFG_W'(ovs));
  endtask

  task automatic wait_quiet();
    item_valid = 1'b0;
    while (model.awaited_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Finish any open sequence so that a register change cannot land mid-conversion.
  task automatic settle_idle();
    while (model.busy)
      send_item(KIND_EOC, '0, model.measuring ? SAMPLE_W'($urandom) : ref_reading());
    wait_quiet();
  endtask

  task automatic run_random(input int n);
    int                  counted;
    logic                k;
    logic [CHAN_W-1:0]   ch;
    logic [SAMPLE_W-1:0] raw;
    counted = 0;
    while (counted < n) begin
      ch  = CHAN_W'($urandom_range((1 << CHAN_W) - 1));
      raw = SAMPLE_W'($urandom);
      if (model.busy) k = ($urandom_range(99) < 30) ? KIND_REQUEST : KIND_EOC;
      else            k = ($urandom_range(99) < 85) ? KIND_REQUEST : KIND_EOC;
      if (k == KIND_EOC && model.busy && !model.measuring) raw = ref_reading();
      if (!(k == KIND_EOC && !model.busy)) counted++;
      send_item(k, ch, raw);
    end
  endtask

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    kind        = KIND_REQUEST;
    req_channel = '0;
    raw_sample  = '0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_VREFINT_CAL;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: zero and tiny reference readings, truncation, idle end event.
    send_item(KIND_REQUEST, 3'd0, '0);
    send_item(KIND_EOC, '0, 16'h0000);
    send_item(KIND_EOC, '0, 16'hFFFF);
    send_item(KIND_EOC, '0, 16'h1234);
    send_item(KIND_REQUEST, REF_CHANNEL, '0);
    send_item(KIND_EOC, '0, 16'h0001);
    send_item(KIND_EOC, '0, 16'hABCD);
    // Pending while busy, and the finished channel asked for again.
    send_item(KIND_REQUEST, 3'd3, '0);
    send_item(KIND_REQUEST, 3'd5, '0);
    send_item(KIND_REQUEST, 3'd3, '0);
    send_item(KIND_EOC, '0, 16'd1655);
    send_item(KIND_EOC, '0, 16'h0FFF);
    send_item(KIND_EOC, '0, 16'hFFFF);
    send_item(KIND_EOC, '0, 16'h8001);
    send_item(KIND_EOC, '0, 16'd2000);
    send_item(KIND_EOC, '0, 16'h1234);
    settle_idle();

    // All-ones settings: 6-bit alignment, oversampling clipped, wrap-around search.
    configure('1, '1, '1);
    send_item(KIND_REQUEST, 3'd2, '0);
    send_item(KIND_EOC, '0, 16'h0001);
    send_item(KIND_EOC, '0, 16'hFFFF);
    send_item(KIND_REQUEST, 3'd6, '0);
    send_item(KIND_REQUEST, 3'd1, '0);
    send_item(KIND_EOC, '0, 16'h0000);
    send_item(KIND_EOC, '0, 16'h003F);
    send_item(KIND_EOC, '0, 16'h0800);
    send_item(KIND_EOC, '0, 16'h5A5A);
    settle_idle();

    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: configure('0, 14'h1B1B, 28'h9876543);
        3: configure('1, '0, '0);
        default: configure(VREF_W'($urandom), RESC_W'($urandom), OVSC_W'($urandom));
      endcase
      unique case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
        3: begin src_idle_pct = 33; sink_stall_pct = 33; end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          // Long output hold-off while beats keep coming, so the input backs up.
          @(posedge clk);
          hold_left = HOLD_CYCLES;
          @(negedge clk);
        end
      endcase
      run_random(PHASE_BEATS);
      settle_idle();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_quiet();
    if (model.awaited_q.size() != 0)
      report($sformatf(" %0d results never arrived", model.awaited_q.size()));
    $display("Covered %0d conversion starts, %0d done reports, %0d requests queued busy,",
             model.n_start, model.n_done, model.n_queued);
    $display("%0d ignored beats, over several register settings and idle/stall mixes.",
             model.n_ignored);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ adc_round_robin_conversion_sequencer.f @@
hw/rtl/adcrr_pkg.sv
hw/rtl/adcrr_div.sv
hw/rtl/adcrr_dp.sv
hw/rtl/adcrr_ctrl.sv
hw/rtl/adc_round_robin_conversion_sequencer.sv
sim/tb_top.sv
